// ----- rtl/mwpp_pkg.sv -----
// types and constants shared by the masked word pattern patcher
// no dependencies
package mwpp_pkg;

    localparam int REPL_DEPTH = 16;
    localparam int REPL_IW    = 4;

    typedef enum logic [1:0] {
        OP_SCAN     = 2'd0,
        OP_LOAD_PAT = 2'd1,
        OP_LOAD_REP = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        CFG_PATTERN_LEN      = 4'd0,
        CFG_REPLACE_OFFSET   = 4'd1,
        CFG_REPL_COUNT       = 4'd2,
        CFG_USE_REPLACE_MASK = 4'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_SCAN,
        K_PAT,
        K_REP
    } t_kind;

    typedef enum logic {
        B_RUN,
        B_FLUSH
    } t_bstate;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  idx;
        logic [31:0] word;
        logic [31:0] mask;
        logic        last;
    } t_item;

    typedef struct packed {
        logic [3:0] pattern_len;
        logic [3:0] replace_offset;
        logic [4:0] repl_count;
        logic       use_replace_mask;
    } t_cfg;

    typedef struct packed {
        logic [31:0] out_word;
        logic        patched;
        logic        match_here;
        logic        end_of_section;
    } t_res;

endpackage

// ----- rtl/mwpp_if.sv -----
// handshake channel interfaces of the patcher: input items, result items, config writes
// depends on nothing
interface mwpp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [3:0]  index;
    logic [31:0] word;
    logic [31:0] mask_word;
    logic        last;
    modport source (output valid, op, index, word, mask_word, last, input ready);
    modport sink (input valid, op, index, word, mask_word, last, output ready);
endinterface

interface mwpp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word;
    logic        patched;
    logic        match_here;
    logic        end_of_section;
    modport source (output valid, out_word, patched, match_here, end_of_section, input ready);
    modport sink (input valid, out_word, patched, match_here, end_of_section, output ready);
endinterface

interface mwpp_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/mwpp_front.sv -----
// front part: accepts input items, classifies them and queues them for the back part
// depends on mwpp_pkg
module mwpp_front #(
    parameter int MAX_PATTERN = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [1:0]     i_op,
    input  logic [3:0]     i_index,
    input  logic [31:0]    i_word,
    input  logic [31:0]    i_mask_word,
    input  logic           i_last,
    output logic           o_q_valid,
    output mwpp_pkg::t_item o_q_item,
    input  logic           i_q_pop
);
    import mwpp_pkg::*;

    t_item       r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push, keep;
    t_item       item;

    assign o_ready = (r_cnt != 2'd2);

    // drop unused ops and pattern loads beyond the table
    always_comb begin
        item.idx  = i_index;
        item.word = i_word;
        item.mask = i_mask_word;
        item.last = i_last;
        item.kind = K_SCAN;
        keep      = 1'b0;
        unique case (t_op'(i_op))
            OP_SCAN: begin
                item.kind = K_SCAN;
                keep      = 1'b1;
            end
            OP_LOAD_PAT: begin
                item.kind = K_PAT;
                keep      = (int'(i_index) < MAX_PATTERN);
            end
            OP_LOAD_REP: begin
                item.kind = K_REP;
                keep      = 1'b1;
            end
            OP_NONE: keep = 1'b0;
        endcase
    end

    assign push      = i_valid && o_ready && keep;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule

// ----- rtl/mwpp_back.sv -----
// back part: tables, sliding window, match and replace step, result register
// depends on mwpp_pkg
module mwpp_back #(
    parameter int WINDOW      = 16,
    parameter int MAX_PATTERN = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mwpp_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    input  mwpp_pkg::t_item i_q_item,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output mwpp_pkg::t_res  o_res
);
    import mwpp_pkg::*;

    localparam int CW   = $clog2(WINDOW + 1);
    localparam int WIW  = $clog2(WINDOW);
    localparam int PIW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PMAX = (MAX_PATTERN < WINDOW) ? MAX_PATTERN : WINDOW;

    logic [31:0] r_pv [MAX_PATTERN];
    logic [31:0] r_pm [MAX_PATTERN];
    logic [31:0] r_rv [REPL_DEPTH];
    logic [31:0] r_rm [REPL_DEPTH];
    logic [31:0] r_win [WINDOW];
    logic        r_pat [WINDOW];
    logic [CW-1:0] r_count, n_count;
    t_bstate     r_state, n_state;
    logic        r_out_valid, n_out_valid;
    t_res        r_out, n_out;

    logic [31:0] ins_w [WINDOW];
    logic        ins_p [WINDOW];
    logic [31:0] src_w [WINDOW];
    logic        src_p [WINDOW];
    logic [31:0] rep_w [WINDOW];
    logic        rep_p [WINDOW];
    logic [CW-1:0] avail;
    logic [4:0]  plen, rlen;
    logic        hit, out_free, do_step, ins_scan, load_win, take_step;
    logic [REPL_DEPTH*32-1:0] rv_flat, rm_flat;
    logic [(WINDOW+REPL_DEPTH)*32-1:0] rv_al, rm_al;

    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    // effective pattern and replacement lengths
    always_comb begin
        plen = {1'b0, i_cfg.pattern_len};
        if (plen == 5'd0) plen = 5'd1;
        if (plen > 5'(PMAX)) plen = 5'(PMAX);
        rlen = (i_cfg.repl_count > 5'(REPL_DEPTH)) ? 5'(REPL_DEPTH) : i_cfg.repl_count;
    end

    // replacement tables lined up with window positions
    always_comb begin
        for (int j = 0; j < REPL_DEPTH; j++) begin
            rv_flat[j*32 +: 32] = r_rv[j];
            rm_flat[j*32 +: 32] = r_rm[j];
        end
        rv_al = {{(WINDOW*32){1'b0}}, rv_flat} << {i_cfg.replace_offset, 5'd0};
        rm_al = {{(WINDOW*32){1'b0}}, rm_flat} << {i_cfg.replace_offset, 5'd0};
    end

    // window with the incoming scan word inserted
    always_comb begin
        for (int t = 0; t < WINDOW; t++) begin
            ins_w[t] = r_win[t];
            ins_p[t] = r_pat[t];
        end
        ins_w[r_count[WIW-1:0]] = i_q_item.word;
        ins_p[r_count[WIW-1:0]] = 1'b0;
    end

    // control
    always_comb begin
        ins_scan  = 1'b0;
        take_step = 1'b0;
        o_q_pop   = 1'b0;
        load_win  = 1'b0;
        n_state   = r_state;
        n_count   = r_count;
        unique case (r_state)
            B_FLUSH: begin
                take_step = out_free;
                if (out_free) begin
                    load_win = 1'b1;
                    n_count  = r_count - CW'(1);
                    if (r_count == CW'(1)) n_state = B_RUN;
                end
            end
            B_RUN: begin
                if (i_q_valid) begin
                    if (i_q_item.kind != K_SCAN) begin
                        o_q_pop = 1'b1;
                    end else if (i_q_item.last) begin
                        o_q_pop  = 1'b1;
                        ins_scan = 1'b1;
                        load_win = 1'b1;
                        n_count  = r_count + CW'(1);
                        n_state  = B_FLUSH;
                    end else if (r_count != CW'(WINDOW - 1)) begin
                        o_q_pop  = 1'b1;
                        ins_scan = 1'b1;
                        load_win = 1'b1;
                        n_count  = r_count + CW'(1);
                    end else if (out_free) begin
                        o_q_pop   = 1'b1;
                        take_step = 1'b1;
                        load_win  = 1'b1;
                    end
                end
            end
        endcase
    end

    assign do_step = take_step;

    // match and replace at the head of the window
    always_comb begin
        if (r_state == B_FLUSH) begin
            for (int t = 0; t < WINDOW; t++) begin
                src_w[t] = r_win[t];
                src_p[t] = r_pat[t];
            end
            avail = r_count;
        end else begin
            for (int t = 0; t < WINDOW; t++) begin
                src_w[t] = ins_w[t];
                src_p[t] = ins_p[t];
            end
            avail = CW'(WINDOW);
        end
        hit = ({3'd0, plen} <= 8'(avail));
        for (int k = 0; k < PMAX; k++) begin
            if ((k < int'(plen)) && ((src_w[k] & r_pm[k]) != r_pv[k])) hit = 1'b0;
        end
        for (int t = 0; t < WINDOW; t++) begin
            rep_w[t] = src_w[t];
            rep_p[t] = src_p[t];
            if (hit && (t >= int'(i_cfg.replace_offset))
                    && (t < int'(i_cfg.replace_offset) + int'(rlen))
                    && (t < int'(avail))) begin
                rep_w[t] = i_cfg.use_replace_mask
                         ? ((src_w[t] & rm_al[t*32 +: 32]) | rv_al[t*32 +: 32])
                         : rv_al[t*32 +: 32];
                rep_p[t] = 1'b1;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        if (do_step) begin
            n_out_valid          = 1'b1;
            n_out.out_word       = rep_w[0];
            n_out.patched        = rep_p[0];
            n_out.match_here     = hit;
            n_out.end_of_section = (r_state == B_FLUSH) && (r_count == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_item.kind == K_PAT) begin
            r_pv[i_q_item.idx[PIW-1:0]] <= i_q_item.word;
            r_pm[i_q_item.idx[PIW-1:0]] <= i_q_item.mask;
        end
        if (o_q_pop && i_q_item.kind == K_REP) begin
            r_rv[i_q_item.idx[REPL_IW-1:0]] <= i_q_item.word;
            r_rm[i_q_item.idx[REPL_IW-1:0]] <= i_q_item.mask;
        end
        if (load_win) begin
            for (int t = 0; t < WINDOW; t++) begin
                if (do_step) begin
                    r_win[t] <= (t < WINDOW - 1) ? rep_w[(t + 1) % WINDOW] : rep_w[t];
                end else if (ins_scan) begin
                    r_win[t] <= ins_w[t];
                end
            end
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_RUN;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int t = 0; t < WINDOW; t++) r_pat[t] <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (load_win) begin
                for (int t = 0; t < WINDOW; t++) begin
                    if (do_step) begin
                        r_pat[t] <= (t < WINDOW - 1) ? rep_p[(t + 1) % WINDOW] : 1'b0;
                    end else if (ins_scan) begin
                        r_pat[t] <= ins_p[t];
                    end
                end
            end
        end
    end
endmodule

// ----- rtl/masked_word_pattern_patcher_top.sv -----
// Masked word pattern patcher. Scan items enter a WINDOW-word sliding window; once the
// window is full each new scan item releases one result item per cycle unless the output
// stalls, after the masked pattern is tested at the head word and any replacement is
// applied in the same cycle. Load items give no result. A scan item with last set starts
// a flush that emits every word held, one per cycle unless the output stalls; the back
// part takes no new item during the flush while a two-entry queue accepts until full.
// Config writes must be made only while the block is idle; the block does not check it.
module masked_word_pattern_patcher_top #(
    parameter int WINDOW      = 16,
    parameter int MAX_PATTERN = 8
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    mwpp_in_if.sink  i_in,
    mwpp_out_if.source o_out,
    mwpp_cfg_if.sink i_cfg
);
    import mwpp_pkg::*;

    t_cfg  r_cfg;
    logic  q_valid, q_pop;
    t_item q_item;
    t_res  res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_len      <= 4'd1;
            r_cfg.replace_offset   <= 4'd0;
            r_cfg.repl_count       <= 5'd0;
            r_cfg.use_replace_mask <= 1'b0;
        end else if (i_cfg.valid) begin
            priority case (i_cfg.index)
                CFG_PATTERN_LEN:      r_cfg.pattern_len      <= i_cfg.data[3:0];
                CFG_REPLACE_OFFSET:   r_cfg.replace_offset   <= i_cfg.data[3:0];
                CFG_REPL_COUNT:       r_cfg.repl_count       <= i_cfg.data[4:0];
                CFG_USE_REPLACE_MASK: r_cfg.use_replace_mask <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    mwpp_front #(.MAX_PATTERN(MAX_PATTERN)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_op        (i_in.op),
        .i_index     (i_in.index),
        .i_word      (i_in.word),
        .i_mask_word (i_in.mask_word),
        .i_last      (i_in.last),
        .o_q_valid   (q_valid),
        .o_q_item    (q_item),
        .i_q_pop     (q_pop)
    );

    mwpp_back #(.WINDOW(WINDOW), .MAX_PATTERN(MAX_PATTERN)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_out.valid),
        .i_ready   (o_out.ready),
        .o_res     (res)
    );

    assign o_out.out_word       = res.out_word;
    assign o_out.patched        = res.patched;
    assign o_out.match_here     = res.match_here;
    assign o_out.end_of_section = res.end_of_section;
endmodule
